FILE: rtl/core/eht_pkg.sv
`timescale 1ns / 1ps

package eht_pkg;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int GD_W     = 3;
  localparam int BC_W     = 7;
  localparam int LD_W     = 3;
  localparam int CAP_W    = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 3'd4;
  localparam logic [APB_AW-1:0] REG_CAP_ADDR = 3'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_BKT,
    S_SCAN,
    S_DECIDE,
    S_DBL,
    S_WALK,
    S_MOVE,
    S_DONE
  } state_e;

  // slot store port control
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

FILE: rtl/core/extendible_hash_table_unit.sv
// Extendible hash table: insert/update, find or remove one key per request.
// Sequence: directory read, bucket depth read, slot scan, decide, then the result is shown;
// the next request is taken once the result has been handed on. An insert into a full bucket
// splits it when room is left (directory walk, slot moves, retried lookup), doubling the
// directory first when its local depth equals the global depth. One request at a time.
// Reset (rst, synchronous): a clearing pass zeroes directory and local depths entry by
// entry; no request is accepted until it ends.
`timescale 1ns / 1ps

module extendible_hash_table_unit #(
  parameter int MAX_DEPTH        = 6,
  parameter int SLOTS_PER_BUCKET = 4,
  parameter int KEY_BITS         = 32,
  parameter int VALUE_BITS       = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // request stream
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // s_tdata: key, value
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]      s_tdata,
  // s_tuser: kind
  input  logic [eht_pkg::KIND_W-1:0]                    s_tuser,
  // result stream
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // m_tdata: found_value, global_depth, bucket_count, local_depth
  output logic [((VALUE_BITS+eht_pkg::GD_W+eht_pkg::BC_W+eht_pkg::LD_W+7)/8)*8-1:0] m_tdata,
  // m_tuser: status
  output logic [eht_pkg::STATUS_W-1:0]                  m_tuser,
  // config port
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [eht_pkg::APB_AW-1:0]                    paddr,
  input  logic [eht_pkg::APB_DW-1:0]                    pwdata,
  output logic [eht_pkg::APB_DW-1:0]                    prdata,
  output logic                                          pready
);
  import eht_pkg::*;

  localparam int DW       = MAX_DEPTH;
  localparam int DIR_SIZE = 1 << MAX_DEPTH;
  localparam int SW       = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CW       = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int AW       = $clog2(DIR_SIZE * SLOTS_PER_BUCKET);
  localparam int DPW      = $clog2(MAX_DEPTH + 1);
  localparam int UW       = DW + 1;
  localparam int CNT_W    = ((DW > SW) ? DW : SW) + 1;
  localparam int OUT_W    = ((VALUE_BITS+GD_W+BC_W+LD_W+7)/8)*8;

  // ---------------------------------------------------------------- state
  state_e state, state_next;
  logic [CNT_W-1:0]      cnt;       // sweep / slot / walk counter
  logic [DPW-1:0]        depth;     // global depth
  logic [UW-1:0]         used;      // buckets in use
  logic [CAP_W-1:0]      cap;
  logic                  hit;
  logic [SLOTS_PER_BUCKET-1:0] vbits [DIR_SIZE];   // slot valid bits per bucket

  // request and working registers
  logic [KIND_W-1:0]     op_kind;
  logic [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0] op_val;
  logic [DW-1:0]         bkt;
  logic [SW-1:0]         hit_slot;
  logic [VALUE_BITS-1:0] found;
  status_e               status;

  // directory and local depth memories
  logic [DW-1:0]  dir_mem [DIR_SIZE];
  logic [DPW-1:0] bd_mem  [DIR_SIZE];
  logic [DW-1:0]  dir_q;
  logic [DPW-1:0] bd_q;
  logic           dir_re, dir_we, bd_re, bd_we;
  logic [DW-1:0]  dir_raddr, dir_waddr, dir_wdata, bd_raddr, bd_waddr;
  logic [DPW-1:0] bd_wdata;

  // slot store
  mem_ctl_t              sl_ctl;
  logic [AW-1:0]         sl_waddr, sl_raddr;
  logic [KEY_BITS-1:0]   sl_wkey, sl_rkey;
  logic [VALUE_BITS-1:0] sl_wval, sl_rval;

  eht_slots #(
    .AW        (AW),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_slots (
    .clk  (clk),
    .ctl  (sl_ctl),
    .waddr(sl_waddr),
    .wkey (sl_wkey),
    .wval (sl_wval),
    .raddr(sl_raddr),
    .rkey (sl_rkey),
    .rval (sl_rval)
  );

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_q <= dir_mem[dir_raddr];
    end
    if (bd_we) begin
      bd_mem[bd_waddr] <= bd_wdata;
    end
    if (bd_re) begin
      bd_q <= bd_mem[bd_raddr];
    end
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [AW-1:0] slot_addr(input logic [DW-1:0] b, input logic [SW-1:0] s);
    return AW'(b) * AW'(SLOTS_PER_BUCKET) + AW'(s);
  endfunction

  function automatic logic [CW-1:0] count_ones(input logic [SLOTS_PER_BUCKET-1:0] v);
    logic [CW-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      n = n + CW'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [SW-1:0] first_free(input logic [SLOTS_PER_BUCKET-1:0] v);
    logic [SW-1:0] f;
    f = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (!v[i]) f = SW'(i);
    end
    return f;
  endfunction

  // ---------------------------------------------------------------- derived values
  logic [UW-1:0]         span;       // directory entries in use
  logic [DW-1:0]         key_idx;
  logic [DW-1:0]         nb;         // bucket created by a split
  logic [SLOTS_PER_BUCKET-1:0] cur_v, nb_v;
  logic [CW-1:0]         fill, cap_eff;
  logic [SW-1:0]         free_cur, free_nb, slot_prev;
  logic [DW-1:0]         j_prev, j_sh;
  logic [KEY_BITS-1:0]   key_sh;
  logic                  match, move_now, at_max, dir_full, bkt_full;
  logic                  out_load, accept;

  assign span      = UW'(1) << depth;
  assign key_idx   = DW'(op_key) & DW'(span - UW'(1));
  assign nb        = DW'(used);
  assign cur_v     = vbits[bkt];
  assign nb_v      = vbits[nb];
  assign fill      = count_ones(cur_v);
  assign free_cur  = first_free(cur_v);
  assign free_nb   = first_free(nb_v);
  assign slot_prev = SW'(cnt - CNT_W'(1));
  assign j_prev    = DW'(cnt - CNT_W'(1));
  assign j_sh      = j_prev >> bd_q;             // split bit of a directory index
  assign key_sh    = sl_rkey >> bd_q;            // split bit of a stored key
  assign at_max    = (depth >= DPW'(MAX_DEPTH));
  assign dir_full  = (used >= UW'(DIR_SIZE));
  assign bkt_full  = (fill >= cap_eff);
  assign match     = (cnt != '0) && cur_v[slot_prev] && (sl_rkey == op_key);
  assign move_now  = (cnt != '0) && cur_v[slot_prev] && key_sh[0];
  assign accept    = s_tvalid && s_tready;
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  // capacity 0 acts as 1, above the slot count as the slot count
  always_comb begin
    if (cap == '0) begin
      cap_eff = CW'(1);
    end else if (int'(cap) > SLOTS_PER_BUCKET) begin
      cap_eff = CW'(SLOTS_PER_BUCKET);
    end else begin
      cap_eff = CW'(cap);
    end
  end

  // ---------------------------------------------------------------- config port
  // word decode: the low two address bits select a byte and are ignored
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_CAP_ADDR[APB_AW-1:2]) ? APB_DW'(cap) : '0;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    dir_re     = 1'b0;
    dir_raddr  = DW'(cnt);
    dir_we     = 1'b0;
    dir_waddr  = j_prev;
    dir_wdata  = '0;
    bd_re      = 1'b0;
    bd_raddr   = dir_q;
    bd_we      = 1'b0;
    bd_waddr   = bkt;
    bd_wdata   = '0;
    sl_ctl     = '0;
    sl_raddr   = slot_addr(bkt, SW'(cnt));
    sl_waddr   = slot_addr(bkt, free_cur);
    sl_wkey    = op_key;
    sl_wval    = op_val;

    case (state)
      S_CLEAR: begin
        // zero directory and local depths, one entry per cycle
        dir_we    = 1'b1;
        dir_waddr = DW'(cnt);
        bd_we     = 1'b1;
        bd_waddr  = DW'(cnt);
        if (cnt == CNT_W'(DIR_SIZE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_DIR;
      end
      S_DIR: begin
        dir_re     = 1'b1;
        dir_raddr  = key_idx;
        state_next = S_BKT;
      end
      S_BKT: begin
        bd_re      = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // read slot cnt, compare slot cnt-1
        if (cnt < CNT_W'(SLOTS_PER_BUCKET)) begin
          sl_ctl.re = 1'b1;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (op_kind == KIND_INSERT) begin
          if (hit) begin
            sl_ctl.we = 1'b1;
            sl_waddr  = slot_addr(bkt, hit_slot);
          end else if (!bkt_full) begin
            sl_ctl.we = 1'b1;
          end else if (bd_q >= depth) begin
            if (!at_max) state_next = S_DBL;
          end else if (!dir_full) begin
            state_next = S_WALK;
          end
        end
      end
      S_DBL: begin
        // copy lower directory half into upper half
        if (cnt < CNT_W'(span)) dir_re = 1'b1;
        if (cnt != '0) begin
          dir_we    = 1'b1;
          dir_waddr = DW'(cnt - CNT_W'(1) + CNT_W'(span));
          dir_wdata = dir_q;
        end
        if (cnt == CNT_W'(span)) state_next = dir_full ? S_DONE : S_WALK;
      end
      S_WALK: begin
        // repoint entries of the split bucket whose split bit is set
        if (cnt < CNT_W'(span)) dir_re = 1'b1;
        if (cnt != '0 && dir_q == bkt && j_sh[0]) begin
          dir_we    = 1'b1;
          dir_wdata = nb;
        end
        if (cnt == '0) begin
          bd_we    = 1'b1;
          bd_waddr = nb;
          bd_wdata = bd_q + DPW'(1);
        end else if (cnt == CNT_W'(1)) begin
          bd_we    = 1'b1;
          bd_wdata = bd_q + DPW'(1);
        end
        if (cnt == CNT_W'(span)) state_next = S_MOVE;
      end
      S_MOVE: begin
        // move entries with the split bit set into the new bucket
        if (cnt < CNT_W'(SLOTS_PER_BUCKET)) sl_ctl.re = 1'b1;
        if (move_now) begin
          sl_ctl.we = 1'b1;
          sl_waddr  = slot_addr(nb, free_nb);
          sl_wkey   = sl_rkey;
          sl_wval   = sl_rval;
        end
        if (cnt == CNT_W'(SLOTS_PER_BUCKET)) state_next = S_DIR;   // retry the insert
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
    end else begin
      state    <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      depth    <= '0;
      used     <= UW'(1);
      cap      <= CAP_RESET;
      hit      <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < DIR_SIZE; i++) begin
        vbits[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_AW-1:2] == REG_CAP_ADDR[APB_AW-1:2]) begin
        cap <= pwdata[CAP_W-1:0];
      end
      m_tvalid <= (m_tvalid && !m_tready) || out_load;

      case (state)
        S_CLEAR: begin
          cnt <= (state_next == S_IDLE) ? '0 : cnt + CNT_W'(1);
        end
        S_BKT: begin
          cnt <= '0;
          hit <= 1'b0;
        end
        S_SCAN: begin
          if (match) hit <= 1'b1;
          cnt <= (state_next == S_DECIDE) ? '0 : cnt + CNT_W'(1);
        end
        S_DECIDE: begin
          cnt <= '0;
          if (op_kind == KIND_REMOVE && hit) begin
            vbits[bkt][hit_slot] <= 1'b0;
          end
          if (op_kind == KIND_INSERT && !hit && !bkt_full) begin
            vbits[bkt][free_cur] <= 1'b1;
          end
        end
        S_DBL: begin
          if (cnt == CNT_W'(span)) begin
            cnt   <= '0;
            depth <= depth + DPW'(1);
          end else begin
            cnt   <= cnt + CNT_W'(1);
          end
        end
        S_WALK: begin
          if (cnt == '0) vbits[nb] <= '0;
          cnt <= (state_next == S_MOVE) ? '0 : cnt + CNT_W'(1);
        end
        S_MOVE: begin
          if (move_now) begin
            vbits[nb][free_nb]    <= 1'b1;
            vbits[bkt][slot_prev] <= 1'b0;
          end
          if (state_next == S_DIR) begin
            cnt  <= '0;
            used <= used + UW'(1);
          end else begin
            cnt  <= cnt + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= s_tuser;
      op_key  <= s_tdata[KEY_BITS-1:0];
      op_val  <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    end
    case (state)
      S_BKT: begin
        bkt   <= dir_q;
        found <= '0;
      end
      S_SCAN: begin
        if (match && !hit) begin
          hit_slot <= slot_prev;
          found    <= sl_rval;
        end
      end
      S_DECIDE: begin
        if (op_kind == KIND_FIND || op_kind == KIND_REMOVE) begin
          status <= hit ? ST_OK : ST_ABSENT;
        end else if (op_kind == KIND_INSERT) begin
          if (hit || !bkt_full) begin
            status <= ST_OK;
          end else if ((bd_q >= depth && at_max) || (bd_q < depth && dir_full)) begin
            status <= ST_FULL;
          end else begin
            status <= ST_ABSENT;
          end
        end else begin
          status <= ST_ABSENT;
        end
      end
      S_DBL: begin
        if (cnt == CNT_W'(span) && dir_full) status <= ST_FULL;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_tuser <= status;
      m_tdata <= OUT_W'({LD_W'(bd_q), BC_W'(used), GD_W'(depth),
                         (op_kind == KIND_FIND && hit) ? found : VALUE_BITS'(0)});
    end
  end

endmodule

FILE: rtl/core/eht_slots.sv
`timescale 1ns / 1ps

// Key/value slot store: one write and one registered read per cycle.
module eht_slots #(
  parameter int AW         = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  eht_pkg::mem_ctl_t     ctl,
  input  logic [AW-1:0]         waddr,
  input  logic [KEY_BITS-1:0]   wkey,
  input  logic [VALUE_BITS-1:0] wval,
  input  logic [AW-1:0]         raddr,
  output logic [KEY_BITS-1:0]   rkey,
  output logic [VALUE_BITS-1:0] rval
);
  import eht_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [KEY_BITS-1:0]   kmem [DEPTH];
  logic [VALUE_BITS-1:0] vmem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      kmem[waddr] <= wkey;
      vmem[waddr] <= wval;
    end
    if (ctl.re) begin
      rkey <= kmem[raddr];
      rval <= vmem[raddr];
    end
  end

endmodule
